// ===== rtl/core/kpet_pkg.sv =====
// Shared types and constants of the key press edge tracker.
// Used by the controller, the datapath, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none
package kpet_pkg;

   localparam int KEY_COUNT_DEF = 256;
   localparam int KEY_W         = 8;

   typedef logic [1:0] op_type;
   typedef logic [1:0] key_status_type;

   localparam op_type OP_KEY_DOWN   = 2'd0;
   localparam op_type OP_KEY_UP     = 2'd1;
   localparam op_type OP_FOCUS_LOST = 2'd2;
   localparam op_type OP_FRAME_TICK = 2'd3;

   localparam key_status_type ST_UP       = 2'd0;
   localparam key_status_type ST_DOWN     = 2'd1;
   localparam key_status_type ST_PRESSED  = 2'd2;
   localparam key_status_type ST_RELEASED = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;      // latch a new word, clear the sweep index
      logic sel_idx;   // status store addressed by the sweep index
      logic st_wr;     // write back the updated status of the addressed key
      logic append;    // link the latched key at the tail of the held list
      logic rem_wr;    // unlink the key whose neighbors were just read
      logic idx_inc;   // step the sweep index
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      op_type op;
      logic   key_ok;      // latched key is below KEY_COUNT
      logic   in_list;     // addressed key is down or pressed
      logic   is_down;     // addressed key is down
      logic   sweep_last;  // sweep index is at the last key
   } sts_type;

endpackage
`default_nettype wire

// ===== rtl/core/kpet_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module kpet_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

// ===== rtl/core/kpet_datapath.sv =====
// Datapath of the key press edge tracker: key status store with valid bits,
// doubly linked held list in two RAMs, head, tail, count and sweep index.
// Depends on kpet_pkg and kpet_ram.
`timescale 1ns / 1ps
`default_nettype none
module kpet_datapath #(
   parameter int KEY_COUNT = kpet_pkg::KEY_COUNT_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire kpet_pkg::cmd_type            cmd,
   output kpet_pkg::sts_type                 sts,
   input  wire kpet_pkg::op_type             req_operation,
   input  wire logic [kpet_pkg::KEY_W-1:0]   req_key_code,
   output kpet_pkg::key_status_type          rsp_key_state,
   output logic      [kpet_pkg::KEY_W-1:0]   rsp_newest_held_key,
   output logic                              rsp_any_held
);
   import kpet_pkg::*;

   localparam int KW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
   localparam int CW = $clog2(KEY_COUNT + 1);
   localparam logic [KEY_W:0] KEY_LIMIT = (KEY_W + 1)'(KEY_COUNT);
   localparam logic [KW-1:0]  LAST_IDX  = KW'(KEY_COUNT - 1);

   op_type            op_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [KW-1:0]     idx_ff;
   logic [KW-1:0]     head_ff, head_in;
   logic [KW-1:0]     tail_ff, tail_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [KEY_COUNT-1:0] valid_ff;
   logic              rdv_ff;

   logic [KW-1:0] key_addr, st_addr, rem_addr;
   logic [2:0]    st_rd, st_eff, st_new;
   key_status_type cur_status;
   logic           cur_seen;

   logic [KW-1:0] prev_rd, next_rd;
   logic          prev_we, next_we;
   logic [KW-1:0] prev_wa, prev_wd, next_wa, next_wd;
   logic          is_head, is_tail;

   assign key_addr = key_ff[KW-1:0];
   assign st_addr  = cmd.sel_idx ? idx_ff : key_addr;
   // Key up removes the latched key; focus lost removes the swept key.
   assign rem_addr = (op_ff == OP_KEY_UP) ? key_addr : idx_ff;

   // An entry never written reads as up and unseen.
   assign st_eff     = rdv_ff ? st_rd : 3'b000;
   assign cur_status = st_eff[1:0];
   assign cur_seen   = st_eff[2];

   always_comb begin
      st_new = {1'b0, ST_RELEASED};
      case (op_ff)
         OP_KEY_DOWN: st_new = {1'b0, ST_PRESSED};
         OP_KEY_UP, OP_FOCUS_LOST: st_new = {1'b0, ST_RELEASED};
         OP_FRAME_TICK: begin
            st_new = {1'b1, cur_status};
            if (cur_seen) begin
               if (cur_status == ST_PRESSED) begin
                  st_new = {1'b1, ST_DOWN};
               end else if (cur_status == ST_RELEASED) begin
                  st_new = {1'b1, ST_UP};
               end
            end
         end
         default: st_new = {1'b0, ST_RELEASED};
      endcase
   end

   kpet_ram #(.WIDTH(3), .DEPTH(KEY_COUNT)) u_status_ram (
      .clock   (clock),
      .wr_en   (cmd.st_wr),
      .wr_addr (st_addr),
      .wr_data (st_new),
      .rd_addr (st_addr),
      .rd_data (st_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.st_wr) begin
         valid_ff[st_addr] <= 1'b1;
      end
      rdv_ff <= valid_ff[st_addr];
   end

   // Held list links: prev and next pointer of every listed key.
   assign is_head = (rem_addr == head_ff);
   assign is_tail = (rem_addr == tail_ff);

   always_comb begin
      prev_we  = 1'b0;
      prev_wa  = key_addr;
      prev_wd  = tail_ff;
      next_we  = 1'b0;
      next_wa  = tail_ff;
      next_wd  = key_addr;
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (cmd.append) begin
         count_in = count_ff + CW'(1);
         tail_in  = key_addr;
         if (count_ff == '0) begin
            head_in = key_addr;
         end else begin
            prev_we = 1'b1;
            next_we = 1'b1;
         end
      end else if (cmd.rem_wr) begin
         count_in = count_ff - CW'(1);
         prev_wa  = next_rd;
         prev_wd  = prev_rd;
         next_wa  = prev_rd;
         next_wd  = next_rd;
         prev_we  = !is_tail;
         next_we  = !is_head;
         if (is_head) begin
            head_in = next_rd;
         end
         if (is_tail) begin
            tail_in = prev_rd;
         end
      end
   end

   kpet_ram #(.WIDTH(KW), .DEPTH(KEY_COUNT)) u_prev_ram (
      .clock   (clock),
      .wr_en   (prev_we),
      .wr_addr (prev_wa),
      .wr_data (prev_wd),
      .rd_addr (rem_addr),
      .rd_data (prev_rd)
   );

   kpet_ram #(.WIDTH(KW), .DEPTH(KEY_COUNT)) u_next_ram (
      .clock   (clock),
      .wr_en   (next_we),
      .wr_addr (next_wa),
      .wr_data (next_wd),
      .rd_addr (rem_addr),
      .rd_data (next_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      head_ff <= head_in;
      tail_ff <= tail_in;
      if (cmd.load) begin
         op_ff  <= req_operation;
         key_ff <= req_key_code;
         idx_ff <= '0;
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_ff + KW'(1);
      end
   end

   assign sts.op         = op_ff;
   assign sts.key_ok     = ({1'b0, key_ff} < KEY_LIMIT);
   assign sts.in_list    = (cur_status == ST_DOWN) || (cur_status == ST_PRESSED);
   assign sts.is_down    = (cur_status == ST_DOWN);
   assign sts.sweep_last = (idx_ff == LAST_IDX);

   assign rsp_key_state       = sts.key_ok ? cur_status : ST_UP;
   assign rsp_any_held        = (count_ff != '0);
   assign rsp_newest_held_key = rsp_any_held ? KEY_W'(tail_ff) : '0;

endmodule
`default_nettype wire

// ===== rtl/core/kpet_ctrl.sv =====
// Controller of the key press edge tracker: sequences key updates,
// list unlinking and the sweeps over all keys.
// Depends on kpet_pkg.
`timescale 1ns / 1ps
`default_nettype none
module kpet_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire kpet_pkg::op_type  req_operation,
   output logic                   busy,
   output logic                   rsp_strobe,
   output kpet_pkg::cmd_type      cmd,
   input  wire kpet_pkg::sts_type sts
);
   import kpet_pkg::*;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_KEY_RD  = 4'd1;
   localparam logic [3:0] S_KEY_CHK = 4'd2;
   localparam logic [3:0] S_SW_RD   = 4'd3;
   localparam logic [3:0] S_SW_CHK  = 4'd4;
   localparam logic [3:0] S_REM_RD  = 4'd5;
   localparam logic [3:0] S_REM_WR  = 4'd6;
   localparam logic [3:0] S_FIN_RD  = 4'd7;
   localparam logic [3:0] S_FIN     = 4'd8;

   logic [3:0] state_ff, state_in;
   logic       accept;
   logic [3:0] sweep_next;

   // The result cycle also takes the next word.
   assign busy       = !((state_ff == S_IDLE) || (state_ff == S_FIN));
   assign rsp_strobe = (state_ff == S_FIN);
   assign accept     = start && !busy;
   assign sweep_next = sts.sweep_last ? S_FIN_RD : S_SW_RD;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE, S_FIN: begin
            if (accept) begin
               cmd.load = 1'b1;
               if (req_operation inside {OP_KEY_DOWN, OP_KEY_UP}) begin
                  state_in = S_KEY_RD;
               end else begin
                  state_in = S_SW_RD;
               end
            end else begin
               state_in = S_IDLE;
            end
         end
         S_KEY_RD: state_in = S_KEY_CHK;
         S_KEY_CHK: begin
            state_in = S_FIN_RD;
            if (sts.key_ok) begin
               if (sts.op == OP_KEY_DOWN) begin
                  if (!sts.in_list) begin
                     cmd.st_wr  = 1'b1;
                     cmd.append = 1'b1;
                  end
               end else begin
                  cmd.st_wr = 1'b1;
                  if (sts.in_list) begin
                     state_in = S_REM_RD;
                  end
               end
            end
         end
         S_SW_RD: begin
            cmd.sel_idx = 1'b1;
            state_in    = S_SW_CHK;
         end
         S_SW_CHK: begin
            cmd.sel_idx = 1'b1;
            if (sts.op == OP_FRAME_TICK) begin
               cmd.st_wr   = 1'b1;
               cmd.idx_inc = 1'b1;
               state_in    = sweep_next;
            end else if (sts.is_down) begin
               // A down key is always on the held list.
               cmd.st_wr = 1'b1;
               state_in  = S_REM_RD;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = sweep_next;
            end
         end
         S_REM_RD: state_in = S_REM_WR;
         S_REM_WR: begin
            cmd.rem_wr = 1'b1;
            if (sts.op == OP_KEY_UP) begin
               state_in = S_FIN_RD;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = sweep_next;
            end
         end
         S_FIN_RD: state_in = S_FIN;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/key_press_edge_tracker.sv =====
// Top level of the key press edge tracker: controller plus datapath.
// Depends on kpet_pkg, kpet_ctrl and kpet_datapath.
//
//   channel   handshake                direction  ports
//   request   start high, busy low     in         req_operation, req_key_code
//   response  rsp_strobe, one cycle    out        rsp_key_state,
//                                                 rsp_newest_held_key, rsp_any_held
//
// Key down and key up pass through a status read, a check and a final read
// before the result cycle; a key up that unlinks a held key also reads and
// then writes the link RAMs. Frame tick and focus lost sweep the status RAM
// one key at a time; frame tick writes back every key, focus lost writes back
// and unlinks each down key. A new word is taken in the result cycle itself.
// Reset clears the controller, the held count and the status valid bits at
// once; there is no clearing pass. The receiver cannot stall the results.
`timescale 1ns / 1ps
`default_nettype none
module key_press_edge_tracker #(
   parameter int KEY_COUNT = kpet_pkg::KEY_COUNT_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire kpet_pkg::op_type            req_operation,
   input  wire logic [kpet_pkg::KEY_W-1:0]  req_key_code,
   output logic                             rsp_strobe,
   output kpet_pkg::key_status_type         rsp_key_state,
   output logic      [kpet_pkg::KEY_W-1:0]  rsp_newest_held_key,
   output logic                             rsp_any_held
);
   import kpet_pkg::*;

   cmd_type cmd;
   sts_type sts;

   kpet_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_operation (req_operation),
      .busy          (busy),
      .rsp_strobe    (rsp_strobe),
      .cmd           (cmd),
      .sts           (sts)
   );

   kpet_datapath #(.KEY_COUNT(KEY_COUNT)) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_operation       (req_operation),
      .req_key_code        (req_key_code),
      .rsp_key_state       (rsp_key_state),
      .rsp_newest_held_key (rsp_newest_held_key),
      .rsp_any_held        (rsp_any_held)
   );

endmodule
`default_nettype wire

// ===== rtl/core/kpet_checker.sv =====
// Port-level checks of the key press edge tracker, bound to the top level.
// Depends on kpet_pkg.
`timescale 1ns / 1ps
`default_nettype none
module kpet_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        start,
   input wire logic                        busy,
   input wire kpet_pkg::op_type            req_operation,
   input wire logic [kpet_pkg::KEY_W-1:0]  req_key_code,
   input wire logic                        rsp_strobe,
   input wire kpet_pkg::key_status_type    rsp_key_state,
   input wire logic [kpet_pkg::KEY_W-1:0]  rsp_newest_held_key,
   input wire logic                        rsp_any_held
);
   import kpet_pkg::*;

   // The result cycle is also the cycle that takes the next word.
   a_strobe_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result shown while busy");

   a_no_early_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_strobe)
      else $error("result right after accept");

   a_key_down_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_operation == OP_KEY_DOWN)) |-> ##4 rsp_strobe)
      else $error("key down word result not after four cycles");

   a_empty_list_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_any_held) |-> (rsp_newest_held_key == '0))
      else $error("newest held key nonzero with empty list");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!busy && !rsp_strobe))
      else $error("not idle after reset");

endmodule

bind key_press_edge_tracker kpet_checker u_kpet_checker (.*);
`default_nettype wire
